FILE: hdl/ebai_pkg.sv
`default_nettype none
package ebai_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int POS_W       = (COL_W > ROW_W) ? COL_W : ROW_W;

  localparam int SIZE_W      = 7;
  localparam int ALPHA_BITS  = 16;
  localparam int PASS_W      = 2;
  localparam int SHIFT_W     = 3;
  localparam int PIX_W       = 8;
  localparam int FRAC_BITS   = 7;
  localparam int ACC_W       = PIX_W + FRAC_BITS;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_BLUR_ALPHA   = 3'd2,
    CFG_PASS_COUNT   = 3'd3,
    CFG_BOOST_SHIFT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_SMOOTH = 2'd0,
    OP_ZERO   = 2'd1,
    OP_BOOST  = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic [SIZE_W-1:0]     width;
    logic [SIZE_W-1:0]     height;
    logic [ALPHA_BITS-1:0] alpha;
    logic [PASS_W-1:0]     passes;
    logic [SHIFT_W-1:0]    boost;
  } cfg_t;

  // One pixel operation handed from the sequencer to the memory pipeline.
  typedef struct packed {
    logic              valid;
    op_kind_t          kind;
    logic [ADDR_W-1:0] addr;
    logic              first;
  } pix_op_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } mem_wr_t;

  // Size registers of 0 act as 1, values above the maximum act as the maximum.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max_v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ebai_store.sv
`default_nettype none
module ebai_store
  import ebai_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_wr_t           wr,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Write-first: a read of the entry being written returns the new word.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == raddr)) begin
      rdata <= wr.data;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ebai_filter.sv
`default_nettype none
module ebai_filter
  import ebai_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pix_op_t               op,
  input  wire logic [ALPHA_BITS-1:0] alpha,
  input  wire logic [SHIFT_W-1:0]    boost,
  input  wire logic [PIX_W-1:0]      rdata,
  output mem_wr_t                    wr
);

  localparam int DIFF_W = ACC_W + 2;
  localparam int PROD_W = ALPHA_BITS + 1 + DIFF_W;
  localparam int STEP_W = PROD_W - ALPHA_BITS;
  localparam int WIDE_W = PIX_W + (1 << SHIFT_W) - 1;

  pix_op_t                   op2_r;
  logic [ACC_W-1:0]          z_r;
  logic [ACC_W-1:0]          z_cur;
  logic [ACC_W-1:0]          z_new;
  logic [ACC_W-1:0]          target;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [STEP_W-1:0]  step;
  logic signed [STEP_W-1:0]  sum;
  logic [WIDE_W-1:0]         shifted;
  logic [PIX_W-1:0]          boost_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op2_r <= '0;
      z_r   <= '0;
    end else begin
      op2_r <= op;
      if (op2_r.valid && (op2_r.kind == OP_SMOOTH)) begin
        z_r <= z_new;
      end
    end
  end

  // The first sample of a sweep starts from an empty accumulator.
  assign z_cur  = op2_r.first ? '0 : z_r;
  assign target = {rdata, {FRAC_BITS{1'b0}}};
  assign diff   = $signed({2'b00, target}) - $signed({2'b00, z_cur});
  assign prod   = $signed({1'b0, alpha}) * diff;
  // Arithmetic right shift rounds toward minus infinity.
  assign step   = STEP_W'(prod >>> ALPHA_BITS);
  assign sum    = $signed({{(STEP_W-ACC_W){1'b0}}, z_cur}) + step;
  assign z_new  = sum[ACC_W-1:0];

  assign shifted   = {{(WIDE_W-PIX_W){1'b0}}, rdata} << boost;
  assign boost_val = (|shifted[WIDE_W-1:PIX_W]) ? PIX_MAX : shifted[PIX_W-1:0];

  always_comb begin
    wr.en   = op2_r.valid;
    wr.addr = op2_r.addr;
    case (op2_r.kind)
      OP_SMOOTH: wr.data = z_new[ACC_W-1:FRAC_BITS];
      OP_BOOST:  wr.data = boost_val;
      default:   wr.data = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/ebai_seq.sv
`default_nettype none
module ebai_seq
  import ebai_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic go,
  input  wire cfg_t cfg,
  output logic      busy,
  output logic      done,
  output pix_op_t   op
);

  typedef enum logic [6:0] {
    SQ_IDLE  = 7'b0000001,
    SQ_FWD   = 7'b0000010,
    SQ_FZERO = 7'b0000100,
    SQ_BWD   = 7'b0001000,
    SQ_BZERO = 7'b0010000,
    SQ_BOOST = 7'b0100000,
    SQ_DRAIN = 7'b1000000
  } seq_state_t;

  seq_state_t        state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  line_r, line_nxt;
  logic              vert_r, vert_nxt;
  logic [PASS_W-1:0] round_r, round_nxt;

  logic [SIZE_W-1:0] w_c, h_c, len, nlines, last_pos, last_line, pos_ext, line_ext;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;

  assign w_c       = clamp_size(cfg.width, SIZE_W'(MAX_WIDTH));
  assign h_c       = clamp_size(cfg.height, SIZE_W'(MAX_HEIGHT));
  assign len       = vert_r ? h_c : w_c;
  assign nlines    = vert_r ? w_c : h_c;
  assign last_pos  = len - SIZE_W'(1);
  assign last_line = nlines - SIZE_W'(1);
  assign pos_ext   = SIZE_W'(pos_r);
  assign line_ext  = SIZE_W'(line_r);

  // A vertical line walks down one column; a horizontal line walks along one row.
  assign row = vert_r ? pos_r[ROW_W-1:0] : line_r[ROW_W-1:0];
  assign col = vert_r ? line_r[COL_W-1:0] : pos_r[COL_W-1:0];

  assign busy = (state_r != SQ_IDLE);

  // A line of one pixel has no samples, only the two end clears.
  function automatic seq_state_t line_entry(input logic [SIZE_W-1:0] n);
    return (n == SIZE_W'(1)) ? SQ_FZERO : SQ_FWD;
  endfunction

  function automatic logic [POS_W-1:0] pos_entry(input logic [SIZE_W-1:0] n);
    return (n == SIZE_W'(1)) ? '0 : POS_W'(1);
  endfunction

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    line_nxt  = line_r;
    vert_nxt  = vert_r;
    round_nxt = round_r;
    done      = 1'b0;
    op.valid  = 1'b0;
    op.kind   = OP_ZERO;
    op.addr   = {row, col};
    op.first  = 1'b0;
    case (state_r)
      SQ_IDLE: begin
        if (go) begin
          round_nxt = '0;
          line_nxt  = '0;
          if (cfg.passes != '0) begin
            vert_nxt  = 1'b1;
            state_nxt = line_entry(h_c);
            pos_nxt   = pos_entry(h_c);
          end else if (cfg.boost != '0) begin
            vert_nxt  = 1'b0;
            pos_nxt   = '0;
            state_nxt = SQ_BOOST;
          end else begin
            state_nxt = SQ_DRAIN;
          end
        end
      end
      SQ_FWD: begin
        op.valid = 1'b1;
        op.kind  = OP_SMOOTH;
        op.first = (pos_r == POS_W'(1));
        if (pos_ext == last_pos) begin
          state_nxt = SQ_FZERO;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      SQ_FZERO: begin
        op.valid = 1'b1;
        if (pos_r == '0) begin
          state_nxt = SQ_BZERO;
        end else begin
          pos_nxt   = pos_r - POS_W'(1);
          state_nxt = SQ_BWD;
        end
      end
      SQ_BWD: begin
        op.valid = 1'b1;
        op.kind  = OP_SMOOTH;
        op.first = ((pos_ext + SIZE_W'(1)) == last_pos);
        if (pos_r == '0) begin
          state_nxt = SQ_BZERO;
        end else begin
          pos_nxt = pos_r - POS_W'(1);
        end
      end
      SQ_BZERO: begin
        op.valid = 1'b1;
        if (line_ext != last_line) begin
          line_nxt  = line_r + POS_W'(1);
          state_nxt = line_entry(len);
          pos_nxt   = pos_entry(len);
        end else if (vert_r) begin
          vert_nxt  = 1'b0;
          line_nxt  = '0;
          state_nxt = line_entry(w_c);
          pos_nxt   = pos_entry(w_c);
        end else if (({1'b0, round_r} + (PASS_W+1)'(1)) == {1'b0, cfg.passes}) begin
          round_nxt = '0;
          line_nxt  = '0;
          pos_nxt   = '0;
          state_nxt = (cfg.boost != '0) ? SQ_BOOST : SQ_DRAIN;
        end else begin
          round_nxt = round_r + PASS_W'(1);
          vert_nxt  = 1'b1;
          line_nxt  = '0;
          state_nxt = line_entry(h_c);
          pos_nxt   = pos_entry(h_c);
        end
      end
      SQ_BOOST: begin
        op.valid = 1'b1;
        op.kind  = OP_BOOST;
        if (pos_ext == last_pos) begin
          pos_nxt = '0;
          if (line_ext == last_line) begin
            state_nxt = SQ_DRAIN;
          end else begin
            line_nxt = line_r + POS_W'(1);
          end
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      SQ_DRAIN: begin
        // The last write-back lands at the end of this cycle.
        done      = 1'b1;
        pos_nxt   = '0;
        line_nxt  = '0;
        vert_nxt  = 1'b0;
        state_nxt = SQ_IDLE;
      end
      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      pos_r   <= '0;
      line_r  <= '0;
      vert_r  <= 1'b0;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
      vert_r  <= vert_nxt;
      round_r <= round_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/exponential_blur_alpha_image.sv
`default_nettype none
// Channel   Ports                                        Handshake
// command   in_cmd, in_pixel_addr, in_pixel_in           start && !busy
// result    out_pixel_out, out_run_done                  out_valid, one cycle
// config    cfg_index, cfg_data                          cfg_we
//
// A write gives no result. A read gives its word in the cycle after it is taken.
// A run walks the pixel memory one access per cycle: pass_count rounds of
// sweeps, then a boost sweep when boost_shift is set; busy is high meanwhile
// and its word comes in the cycle busy falls. Reset clears control state and
// returns the configuration to its defaults; pixel contents are kept. Results
// cannot be held off.
module exponential_blur_alpha_image
  import ebai_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [CMD_W-1:0]      in_cmd,
  input  wire logic [ADDR_W-1:0]     in_pixel_addr,
  input  wire logic [PIX_W-1:0]      in_pixel_in,
  output logic                       out_valid,
  output logic [PIX_W-1:0]           out_pixel_out,
  output logic                       out_run_done,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg_r;
  logic             out_valid_r, out_valid_nxt;
  logic             run_done_r;
  logic             rd_pend_r;
  logic             accept, host_we, host_rd, run_go, seq_done;
  pix_op_t          op;
  mem_wr_t          pipe_wr, mem_wr;
  logic [ADDR_W-1:0] raddr;
  logic [PIX_W-1:0] rdata;

  assign accept  = start && !busy;
  assign host_we = accept && (in_cmd == CMD_WRITE);
  assign run_go  = accept && (in_cmd == CMD_RUN);
  assign host_rd = accept && (in_cmd == CMD_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= SIZE_W'(MAX_WIDTH);
      cfg_r.height <= SIZE_W'(MAX_HEIGHT);
      cfg_r.alpha  <= '0;
      cfg_r.passes <= '0;
      cfg_r.boost  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_r.width  <= cfg_data[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_r.height <= cfg_data[SIZE_W-1:0];
        CFG_BLUR_ALPHA:   cfg_r.alpha  <= cfg_data[ALPHA_BITS-1:0];
        CFG_PASS_COUNT:   cfg_r.passes <= cfg_data[PASS_W-1:0];
        CFG_BOOST_SHIFT:  cfg_r.boost  <= cfg_data[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ebai_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (run_go),
    .cfg   (cfg_r),
    .busy  (busy),
    .done  (seq_done),
    .op    (op)
  );

  ebai_filter u_filter (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .alpha (cfg_r.alpha),
    .boost (cfg_r.boost),
    .rdata (rdata),
    .wr    (pipe_wr)
  );

  // The pipeline owns the write port while a run is going; host writes come when idle.
  always_comb begin
    if (pipe_wr.en) begin
      mem_wr = pipe_wr;
    end else begin
      mem_wr.en   = host_we;
      mem_wr.addr = in_pixel_addr;
      mem_wr.data = in_pixel_in;
    end
  end

  assign raddr = busy ? op.addr : in_pixel_addr;

  ebai_store u_store (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_valid_nxt = host_rd || seq_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      run_done_r  <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      run_done_r  <= seq_done;
      rd_pend_r   <= host_rd;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_run_done  = run_done_r;
  assign out_pixel_out = rd_pend_r ? rdata : '0;

`ifndef SYNTHESIS
  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(pipe_wr.en && host_we))
    else $error("host write collides with a pipeline write-back");

  a_pipe_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_wr.en |-> $past(busy))
    else $error("pipeline write-back outside a run");

  a_run_word_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_run_done && (out_pixel_out == '0)))
    else $error("run finished without its result word");
`endif

endmodule
`default_nettype wire
